>>> hdl/etfp_pkg.sv
package etfp_pkg;

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned PIX_W     = 10;
  localparam int unsigned ITER_W    = 16;
  localparam int unsigned PROD_W    = PIX_W + STEP_W;
  localparam int unsigned SAT_W     = PROD_W + 3;
  localparam int unsigned MUL_W     = 2 * WORD_W;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_X_START    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_START    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_RE    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_IM    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 4'd7;

  localparam logic [WORD_W-1:0] RST_X_START    = 32'hE000_0000;
  localparam logic [WORD_W-1:0] RST_Y_START    = 32'hECCC_CCCD;
  localparam logic [STEP_W-1:0] RST_X_STEP     = 31'd786432;
  localparam logic [STEP_W-1:0] RST_Y_STEP     = 31'd838861;
  localparam logic [ITER_W-1:0] RST_ITER_LIMIT = 16'd1000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic [ITER_W-1:0] iter_count;
    logic              in_set;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } result_t;

  typedef struct packed {
    logic [WORD_W-1:0] x_start;
    logic [WORD_W-1:0] y_start;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
    logic              julia_mode;
    logic [WORD_W-1:0] seed_re;
    logic [WORD_W-1:0] seed_im;
    logic [ITER_W-1:0] iter_limit;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] zr;
    logic [WORD_W-1:0] zi;
    logic [WORD_W-1:0] cr;
    logic [WORD_W-1:0] ci;
  } work_t;

  function automatic logic [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'($signed({1'b0, {(WORD_W-1){1'b1}}}));
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

endpackage

>>> hdl/etfp_front.sv
module etfp_front
  import etfp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  pixel_t pix_i,
  input  cfg_t   cfg_i,
  output logic   busy_o,
  output logic   push_valid_o,
  input  logic   push_ready_i,
  output work_t  push_data_o
);

  logic              valid_q;
  logic [PROD_W-1:0] xprod_q;
  logic [PROD_W-1:0] yprod_q;
  logic              accept;
  logic              push;
  logic signed [SAT_W-1:0] px_sum;
  logic signed [SAT_W-1:0] py_sum;
  logic [WORD_W-1:0] px;
  logic [WORD_W-1:0] py;

  assign busy_o       = valid_q && !push_ready_i;
  assign accept       = start_i && !busy_o;
  assign push         = valid_q && push_ready_i;
  assign push_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xprod_q <= PROD_W'(pix_i.pixel_col) * PROD_W'(cfg_i.x_step);
      yprod_q <= PROD_W'(pix_i.pixel_row) * PROD_W'(cfg_i.y_step);
    end
  end

  always_comb begin
    px_sum = $signed({{(SAT_W-WORD_W){cfg_i.x_start[WORD_W-1]}}, cfg_i.x_start})
           + $signed({{(SAT_W-PROD_W){1'b0}}, xprod_q});
    py_sum = $signed({{(SAT_W-WORD_W){cfg_i.y_start[WORD_W-1]}}, cfg_i.y_start})
           + $signed({{(SAT_W-PROD_W){1'b0}}, yprod_q});
    px = sat32(px_sum);
    py = sat32(py_sum);
    if (cfg_i.julia_mode) begin
      push_data_o = '{zr: px, zi: py, cr: cfg_i.seed_re, ci: cfg_i.seed_im};
    end else begin
      push_data_o = '{zr: '0, zi: '0, cr: px, ci: py};
    end
  end

endmodule

>>> hdl/etfp_fifo.sv
module etfp_fifo
  import etfp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t wdata_i,
  input  logic  pop_i,
  output work_t rdata_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  work_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == (PTR_W + 1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hdl/etfp_iter.sv
module etfp_iter
  import etfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              work_valid_i,
  input  work_t             work_i,
  output logic              pop_o,
  input  logic [ITER_W-1:0] iter_limit_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } state_e;

  localparam logic signed [MUL_W-1:0] LIMIT = MUL_W'(4) <<< FRAC_BITS;

  state_e            state_q;
  logic [WORD_W-1:0] zr_q;
  logic [WORD_W-1:0] zi_q;
  logic [WORD_W-1:0] cr_q;
  logic [WORD_W-1:0] ci_q;
  logic [ITER_W-1:0] n_q;
  logic signed [MUL_W-1:0] sqr_q;
  logic signed [MUL_W-1:0] sqi_q;
  logic signed [MUL_W-1:0] crs_q;
  logic              res_valid_q;
  result_t           res_q;

  logic signed [MUL_W-1:0] sr;
  logic signed [MUL_W-1:0] si;
  logic signed [MUL_W-1:0] cross_term;
  logic signed [MUL_W-1:0] re_sum;
  logic signed [MUL_W-1:0] im_sum;
  logic              escape;
  logic [ITER_W-1:0] n_inc;
  logic [WORD_W-1:0] zr_next;
  logic [WORD_W-1:0] zi_next;

  function automatic result_t make_result(input logic [ITER_W-1:0] n,
                                          input logic [ITER_W-1:0] lim);
    result_t r;
    r.iter_count = n;
    r.in_set     = (n == lim);
    r.red        = r.in_set ? 8'd0 : 8'(n * ITER_W'(9));
    r.green      = r.in_set ? 8'd0 : 8'(n * ITER_W'(2));
    r.blue       = r.in_set ? 8'd0 : 8'(n * ITER_W'(15));
    return r;
  endfunction

  assign pop_o       = (state_q == ST_IDLE) && work_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    sr         = sqr_q >>> FRAC_BITS;
    si         = sqi_q >>> FRAC_BITS;
    cross_term = crs_q >>> (FRAC_BITS - 1);
    escape     = (sr + si) > LIMIT;
    re_sum     = sr - si + MUL_W'($signed(cr_q));
    im_sum     = cross_term + MUL_W'($signed(ci_q));
    zr_next    = sat32(re_sum[SAT_W-1:0]);
    zi_next    = sat32(im_sum[SAT_W-1:0]);
    n_inc      = n_q + ITER_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (work_valid_i) begin
            zr_q <= work_i.zr;
            zi_q <= work_i.zi;
            cr_q <= work_i.cr;
            ci_q <= work_i.ci;
            n_q  <= '0;
            if (iter_limit_i == '0) begin
              res_valid_q <= 1'b1;
              res_q       <= make_result('0, iter_limit_i);
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          sqr_q   <= $signed(zr_q) * $signed(zr_q);
          sqi_q   <= $signed(zi_q) * $signed(zi_q);
          crs_q   <= $signed(zr_q) * $signed(zi_q);
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (escape) begin
            res_valid_q <= 1'b1;
            res_q       <= make_result(n_q, iter_limit_i);
            state_q     <= ST_IDLE;
          end else begin
            zr_q <= zr_next;
            zi_q <= zi_next;
            n_q  <= n_inc;
            if (n_inc == iter_limit_i) begin
              res_valid_q <= 1'b1;
              res_q       <= make_result(n_inc, iter_limit_i);
              state_q     <= ST_IDLE;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/escape_time_fractal_pixel_core.sv
// Channel   Direction  Handshake                  Beat
// pixel     in         start high, busy low       pix_i (column, row)
// result    out        res_valid_o, one cycle     res_o (count, in-set flag, colour)
// config    in         cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
// A pixel is registered in the front, then written into the queue, then takes a multiply
// state and an update state per iteration until it escapes or reaches the limit; with a
// zero limit its result is registered straight from idle.
// A two-beat queue lets new pixels in while one iterates; busy is high only when it is full.
// Reset clears control state and loads the default view; there is no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module escape_time_fractal_pixel_core
  import etfp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pixel_t               pix_i,
  output logic                 res_valid_o,
  output result_t              res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  cfg_t  cfg_q;
  logic  push_valid;
  work_t push_data;
  logic  fifo_full;
  logic  fifo_empty;
  work_t pop_data;
  logic  pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_start    <= RST_X_START;
      cfg_q.y_start    <= RST_Y_START;
      cfg_q.x_step     <= RST_X_STEP;
      cfg_q.y_step     <= RST_Y_STEP;
      cfg_q.julia_mode <= 1'b0;
      cfg_q.seed_re    <= '0;
      cfg_q.seed_im    <= '0;
      cfg_q.iter_limit <= RST_ITER_LIMIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_X_START:    cfg_q.x_start    <= cfg_data_i;
        REG_Y_START:    cfg_q.y_start    <= cfg_data_i;
        REG_X_STEP:     cfg_q.x_step     <= cfg_data_i[STEP_W-1:0];
        REG_Y_STEP:     cfg_q.y_step     <= cfg_data_i[STEP_W-1:0];
        REG_JULIA_MODE: cfg_q.julia_mode <= cfg_data_i[0];
        REG_SEED_RE:    cfg_q.seed_re    <= cfg_data_i;
        REG_SEED_IM:    cfg_q.seed_im    <= cfg_data_i;
        REG_ITER_LIMIT: cfg_q.iter_limit <= cfg_data_i[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  etfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .pix_i        (pix_i),
    .cfg_i        (cfg_q),
    .busy_o       (busy),
    .push_valid_o (push_valid),
    .push_ready_i (!fifo_full),
    .push_data_o  (push_data)
  );

  etfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_valid),
    .wdata_i (push_data),
    .pop_i   (pop),
    .rdata_o (pop_data),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  etfp_iter u_iter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (!fifo_empty),
    .work_i       (pop_data),
    .pop_o        (pop),
    .iter_limit_i (cfg_q.iter_limit),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  a_black_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.in_set |->
      res_o.red == 8'd0 && res_o.green == 8'd0 && res_o.blue == 8'd0)
    else $error("Colour is not black for a point inside the set.");

  a_in_set_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.in_set == (res_o.iter_count == cfg_q.iter_limit))
    else $error("In-set flag disagrees with the iteration count.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.iter_count <= cfg_q.iter_limit)
    else $error("Iteration count exceeds the limit.");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && fifo_full |-> busy)
    else $error("Front accepts a pixel while its beat cannot enter the queue.");

endmodule
